// ----- src/ess_pkg.sv -----
// ess_pkg: shared widths, opcodes, register map and the queue entry type
// for the edge structural similarity block. No dependencies.
package ess_pkg;

	localparam int ROW_W  = 64;
	localparam int NODE_W = 6;
	localparam int CNT_W  = 7;
	localparam int SIM_W  = 18;
	localparam int CFG_W  = 7;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int QDEPTH = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register index is paddr[2]
	localparam logic REG_NODES_IDX = 1'b0;
	localparam logic [CFG_W-1:0] NODES_RESET = 7'd64;

	localparam logic [SIM_W-1:0] SIM_MAX = 18'd131072;

	typedef struct packed {
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [CNT_W-1:0]  common;
		logic [CNT_W-1:0]  deg_a;
		logic [CNT_W-1:0]  deg_b;
	} qent_t;

endpackage

// ----- src/ess_front.sv -----
// ess_front: accepts commands, holds the adjacency memory, reads both rows
// of a queried edge and counts degrees and common neighbors. Uses ess_pkg.
module ess_front import ess_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              opcode,
	input  logic [NODE_W-1:0] first_node,
	input  logic [NODE_W-1:0] second_node,
	input  logic [ROW_W-1:0]  row_bits,
	input  logic [CFG_W-1:0]  nodes_in_use,
	input  logic              q_full,
	output logic              busy,
	output logic              push,
	output qent_t             push_data
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NGRP = ROW_W / 8;

	function automatic logic [3:0] pc8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

	logic [MAX_NODES-1:0] mem [MAX_NODES];

	logic                 v_s1, v_s2;
	logic [MAX_NODES-1:0] rda_s1, rdb_s1;
	logic                 ina_s1, inb_s1;
	logic [NODE_W-1:0]    a_s1, b_s1, a_s2, b_s2;
	logic [3:0]           cc_s2 [NGRP];
	logic [3:0]           ca_s2 [NGRP];
	logic [3:0]           cb_s2 [NGRP];

	logic          acc, acc_load, acc_query;
	logic          in_a, in_b;
	logic [AW-1:0] a_idx, b_idx;
	logic [CFG_W-1:0] n_eff;
	logic [ROW_W-1:0] mask, ra, rb, rc;
	logic [CNT_W-1:0] sum_c, sum_a, sum_b;

	assign busy      = v_s1 | v_s2 | q_full;
	assign acc       = start & ~busy;
	assign acc_load  = acc & (opcode == OP_LOAD);
	assign acc_query = acc & (opcode == OP_QUERY);
	assign in_a      = (CNT_W'(first_node) < CNT_W'(MAX_NODES));
	assign in_b      = (CNT_W'(second_node) < CNT_W'(MAX_NODES));
	assign a_idx     = first_node[AW-1:0];
	assign b_idx     = second_node[AW-1:0];

	always_ff @(posedge clk) begin
		if (acc_load && in_a) begin
			mem[a_idx] <= row_bits[MAX_NODES-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_query) begin
			rda_s1 <= mem[a_idx];
			rdb_s1 <= mem[b_idx];
			ina_s1 <= in_a;
			inb_s1 <= in_b;
			a_s1   <= first_node;
			b_s1   <= second_node;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc_query;
			v_s2 <= v_s1;
		end
	end

	// column mask: only nodes below the clamped node count take part
	always_comb begin
		n_eff = (nodes_in_use > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_in_use;
		for (int j = 0; j < ROW_W; j++) begin
			mask[j] = (CFG_W'(j) < n_eff);
		end
		ra = ina_s1 ? (ROW_W'(rda_s1) & mask) : '0;
		rb = inb_s1 ? (ROW_W'(rdb_s1) & mask) : '0;
		rc = ra & rb;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			for (int g = 0; g < NGRP; g++) begin
				cc_s2[g] <= pc8(rc[8*g +: 8]);
				ca_s2[g] <= pc8(ra[8*g +: 8]);
				cb_s2[g] <= pc8(rb[8*g +: 8]);
			end
		end
	end

	always_comb begin
		sum_c = '0;
		sum_a = '0;
		sum_b = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_c = sum_c + CNT_W'(cc_s2[g]);
			sum_a = sum_a + CNT_W'(ca_s2[g]);
			sum_b = sum_b + CNT_W'(cb_s2[g]);
		end
	end

	assign push             = v_s2;
	assign push_data.node_a = a_s2;
	assign push_data.node_b = b_s2;
	assign push_data.common = sum_c;
	assign push_data.deg_a  = sum_a;
	assign push_data.deg_b  = sum_b;

endmodule

// ----- src/ess_queue.sv -----
// ess_queue: short FIFO of counted queries between front and back.
// Uses ess_pkg for the entry type and depth.
module ess_queue import ess_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t pop_data,
	output logic  full,
	output logic  not_empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	qent_t         store_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (cnt_q == CW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/ess_back.sv -----
// ess_back: takes counted queries from the queue and finds the similarity
// one result bit per cycle, msb first. Uses ess_pkg.
module ess_back import ess_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  qent_t             q_data,
	output logic              pop,
	output logic              done,
	output logic [NODE_W-1:0] edge_start,
	output logic [NODE_W-1:0] edge_end,
	output logic [SIM_W-1:0]  similarity,
	output logic [CNT_W-1:0]  common_neighbors,
	output logic [CNT_W-1:0]  start_degree,
	output logic [CNT_W-1:0]  end_degree
);

	localparam int ACC_W  = 50;
	localparam int PROD_W = 13;
	localparam int BIT_W  = 5;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_ITER  = 2'd2;

	logic [1:0]       state_q;
	qent_t            ent_q;
	logic [BIT_W-1:0] bit_q;
	logic [ACC_W-1:0] s_q, x_q, y_q, tgt_q;
	logic [SIM_W-1:0] root_q;
	logic             done_q;

	logic [7:0]       da1, db1, num;
	logic [15:0]      prod_w, nsq_w;
	logic [ACC_W-1:0] cand, x_take;
	logic             take;
	logic [SIM_W-1:0] root_nxt;

	assign pop = (state_q == ST_IDLE) & q_valid;

	always_comb begin
		da1    = {1'b0, ent_q.deg_a} + 8'd1;
		db1    = {1'b0, ent_q.deg_b} + 8'd1;
		num    = {1'b0, ent_q.common} + 8'd2;
		prod_w = da1 * db1;
		nsq_w  = num * num;
		// S = q^2*prod, X = q*prod << (b+1), Y = prod << 2b
		cand     = s_q + x_q + y_q;
		take     = (cand <= tgt_q);
		x_take   = take ? (x_q + (y_q << 1)) : x_q;
		root_nxt = {root_q[SIM_W-2:0], take};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ent_q <= q_data;
				end
			end
			ST_SETUP: begin
				s_q    <= '0;
				x_q    <= '0;
				y_q    <= ACC_W'(prod_w[PROD_W-1:0]) << (2 * (SIM_W - 1));
				tgt_q  <= ACC_W'(nsq_w[PROD_W-1:0]) << 32;
				root_q <= '0;
			end
			ST_ITER: begin
				if (take) begin
					s_q <= cand;
				end
				x_q    <= x_take >> 1;
				y_q    <= y_q >> 2;
				root_q <= root_nxt;
				if (bit_q == '0) begin
					edge_start       <= ent_q.node_a;
					edge_end         <= ent_q.node_b;
					similarity       <= root_nxt;
					common_neighbors <= ent_q.common;
					start_degree     <= ent_q.deg_a;
					end_degree       <= ent_q.deg_b;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					bit_q   <= BIT_W'(SIM_W - 1);
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (bit_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule

// ----- src/edge_structural_similarity.sv -----
// edge_structural_similarity: top level with the APB register, the front
// (memory and counting), the query queue and the root/divide back unit.
// Depends on ess_pkg, ess_front, ess_queue, ess_back.
//
// Usage: drive start with opcode and the node/row fields; the command is a
// transaction when start is high and busy is low. A load (opcode 0) writes
// one adjacency row in that cycle and gives no result. A query (opcode 1)
// gives one result: done is high for exactly one cycle with the edge ids,
// counts and similarity on the result ports; the receiver cannot stall it.
// A query holds busy while it is in the counting stages, so the front takes
// a new command only after they clear and while the two-entry queue has
// room; the back unit handles one query at a time (pop, setup, 18 root
// steps), which sets the sustained rate. Loads are accepted whenever busy
// is low. nodes_in_use sits at byte address 0 of the APB port (pready
// always high); the user must write it only while the block is idle, which
// the block does not enforce. Reset sets nodes_in_use to 64 and empties the
// pipeline; adjacency rows are undefined until loaded.
module edge_structural_similarity import ess_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [NODE_W-1:0] first_node,
	input  logic [NODE_W-1:0] second_node,
	input  logic [ROW_W-1:0]  row_bits,
	output logic              done,
	output logic [NODE_W-1:0] edge_start,
	output logic [NODE_W-1:0] edge_end,
	output logic [SIM_W-1:0]  similarity,
	output logic [CNT_W-1:0]  common_neighbors,
	output logic [CNT_W-1:0]  start_degree,
	output logic [CNT_W-1:0]  end_degree,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [CFG_W-1:0] nodes_q;
	logic             q_full, q_valid, push, pop;
	qent_t            push_data, pop_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODES_IDX) ? DATA_W'(nodes_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= NODES_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODES_IDX)) begin
			nodes_q <= pwdata[CFG_W-1:0];
		end
	end

	ess_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.first_node  (first_node),
		.second_node (second_node),
		.row_bits    (row_bits),
		.nodes_in_use(nodes_q),
		.q_full      (q_full),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data)
	);

	ess_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.not_empty(q_valid)
	);

	ess_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_data          (pop_data),
		.pop             (pop),
		.done            (done),
		.edge_start      (edge_start),
		.edge_end        (edge_end),
		.similarity      (similarity),
		.common_neighbors(common_neighbors),
		.start_degree    (start_degree),
		.end_degree      (end_degree)
	);

endmodule

// ----- src/ess_checker.sv -----
// ess_checker: port-level assertions for edge_structural_similarity and the
// bind that attaches them. Uses ess_pkg.
module ess_checker import ess_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             opcode,
	input logic             done,
	input logic [SIM_W-1:0] similarity,
	input logic [CNT_W-1:0] common_neighbors,
	input logic [CNT_W-1:0] start_degree,
	input logic [CNT_W-1:0] end_degree
);

	// a query occupies the counting stages
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_QUERY) |=> busy)
		else $error("busy low right after a query transaction");

	// a load never occupies the front
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_LOAD) |=> !busy)
		else $error("busy raised by a load transaction");

	// the root unit never gives results back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (similarity <= SIM_MAX) && (common_neighbors <= start_degree)
			&& (common_neighbors <= end_degree))
		else $error("result counts or similarity out of range");

endmodule

bind edge_structural_similarity ess_checker u_ess_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.opcode          (opcode),
	.done            (done),
	.similarity      (similarity),
	.common_neighbors(common_neighbors),
	.start_degree    (start_degree),
	.end_degree      (end_degree)
);
